@@ rtl/button_bank_debounce_long_press_macros.svh @@
// ---------------------------------------------------------------------------
// button bank debouncer assertion macros
// shared concurrent assertion forms, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef BUTTON_BANK_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_BANK_DEBOUNCE_LONG_PRESS_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define BBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbd assertion failed");
// next-cycle implication, checked out of reset
`define BBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbd assertion failed");
`else
`define BBD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/bbd_pkg.sv @@
// ---------------------------------------------------------------------------
// bbd_pkg
// types and constants shared by the button bank debouncer
// ---------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int RAW_W      = 8;
    localparam int SEL_W      = 3;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;
    localparam int RES_W      = 26;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE_DELAY  = 3'd0,
        CFG_LONG_PRESS_TIME = 3'd1,
        CFG_PRESSED_POL     = 3'd2,
        CFG_LONG_PRESS_EN   = 3'd3,
        CFG_LONG_PRESS_BTN  = 3'd4
    } cfg_index_t;

    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [DELAY_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // per-lane findings for the current poll
    typedef struct packed {
        logic press;
        logic release_ev;
        logic pressed;
        logic lp_ready;
    } lane_status_t;

    // result word fields
    typedef struct packed {
        logic             input_detected;
        logic [RAW_W-1:0] stable_pressed;
        logic             long_press_event;
        logic [RAW_W-1:0] release_mask;
        logic [RAW_W-1:0] press_mask;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/button_bank_debounce_long_press.sv @@
// ---------------------------------------------------------------------------
// button_bank_debounce_long_press
// timestamped debouncer for a bank of buttons with long-press detection
// ---------------------------------------------------------------------------
// Each input word carries a millisecond timestamp and the raw button levels;
// every word gives exactly one result word. One lane per button does the
// 32-bit elapsed-time compare in the accept cycle, so a poll is taken every
// clock and its result appears in the output register in the cycle after.
// Throughput is set only by the output register: a stalled result word
// holds the input off until it is taken.
`default_nettype none

module button_bank_debounce_long_press #(
    parameter int NUM_BUTTONS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [bbd_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [bbd_pkg::CFG_W-1:0]      cfg_data,
    // poll input
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], raw_levels[39:32]
    input  wire logic [bbd_pkg::IN_DATA_W-1:0]  s_tdata,
    // result output
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // press_mask[7:0], release_mask[15:8], long_press_event[16],
    // stable_pressed[24:17], input_detected[25], zero[31:26]
    output logic [bbd_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import bbd_pkg::*;

    `include "button_bank_debounce_long_press_macros.svh"

    logic [DELAY_W-1:0]    debounce_reg;
    logic [DELAY_W-1:0]    long_time_reg;
    logic [RAW_W-1:0]      pol_reg;
    logic                  lp_en_reg;
    logic [SEL_W-1:0]      lp_btn_reg;

    logic                  accept;
    logic [TIME_W-1:0]     now_ms;
    logic [RAW_W-1:0]      raw_levels;
    lane_status_t          lanes [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] lp_fire;
    result_t               result;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            long_time_reg <= LONG_PRESS_RESET;
            pol_reg       <= '0;
            lp_en_reg     <= 1'b0;
            lp_btn_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_DELAY:  debounce_reg  <= cfg_data;
                CFG_LONG_PRESS_TIME: long_time_reg <= cfg_data;
                CFG_PRESSED_POL:     pol_reg       <= cfg_data[RAW_W-1:0];
                CFG_LONG_PRESS_EN:   lp_en_reg     <= cfg_data[0];
                CFG_LONG_PRESS_BTN:  lp_btn_reg    <= cfg_data[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign now_ms     = s_tdata[TIME_W-1:0];
    assign raw_levels = s_tdata[TIME_W+RAW_W-1:TIME_W];

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        logic reading;
        logic pol;

        // buttons past the raw field read low with low polarity
        if (i < RAW_W)
        begin : g_in
            assign reading = raw_levels[i];
            assign pol     = pol_reg[i];
        end
        else
        begin : g_zero
            assign reading = 1'b0;
            assign pol     = 1'b0;
        end

        bbd_lane u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .accept          (accept),
            .now_ms          (now_ms),
            .reading         (reading),
            .pol             (pol),
            .debounce_delay  (debounce_reg),
            .long_press_time (long_time_reg),
            .lp_fire         (lp_fire[i]),
            .status          (lanes[i])
        );
    end

    bbd_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .lanes     (lanes),
        .lp_enable (lp_en_reg),
        .lp_button (lp_btn_reg),
        .lp_fire   (lp_fire),
        .result    (result)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {{(OUT_DATA_W-RES_W){1'b0}}, result};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a press and a release of the same button never share a word
    `BBD_ASSERT_IMPL(a_press_release_disjoint, clk, rst_n, m_tvalid,
        (m_tdata[7:0] & m_tdata[15:8]) == 8'd0)
    // detection flag matches the events it summarizes
    `BBD_ASSERT_IMPL(a_detect_consistent, clk, rst_n, m_tvalid,
        m_tdata[25] == ((|m_tdata[7:0]) || (|m_tdata[15:8]) || m_tdata[16]))
    // at most one lane fires a long press per poll
    `BBD_ASSERT_IMPL(a_fire_onehot, clk, rst_n, 1'b1, $onehot0(lp_fire))
    // an accepted poll always leaves a result word behind
    `BBD_ASSERT_NEXT(a_accept_gives_word, clk, rst_n, accept, m_tvalid)
    // an empty output register never blocks the input
    `BBD_ASSERT_IMPL(a_empty_ready, clk, rst_n, !m_tvalid, s_tready)

endmodule

`default_nettype wire

@@ rtl/bbd_lane.sv @@
// ---------------------------------------------------------------------------
// bbd_lane
// debounce and long-press timing state of one button
// ---------------------------------------------------------------------------
`default_nettype none

module bbd_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [bbd_pkg::TIME_W-1:0]  now_ms,
    input  wire logic                        reading,
    input  wire logic                        pol,
    input  wire logic [bbd_pkg::DELAY_W-1:0] debounce_delay,
    input  wire logic [bbd_pkg::DELAY_W-1:0] long_press_time,
    input  wire logic                        lp_fire,
    output bbd_pkg::lane_status_t            status
);
    import bbd_pkg::*;

    logic              prev_reg, prev_next;
    logic              stable_reg, stable_next;
    logic [TIME_W-1:0] change_reg, change_next;
    logic              done_reg, done_next;
    logic              changed;
    logic [TIME_W-1:0] elapsed;
    logic              update;

    always_comb
    begin
        changed     = (reading != prev_reg);
        change_next = changed ? now_ms : change_reg;
        // elapsed since the (possibly just restarted) change time
        elapsed     = changed ? '0 : (now_ms - change_reg);
        update      = (elapsed > {{(TIME_W-DELAY_W){1'b0}}, debounce_delay})
                      && (reading != stable_reg);
        stable_next = update ? reading : stable_reg;
        prev_next   = reading;

        status.press      = update && (reading == pol);
        status.release_ev = update && (reading != pol);
        status.pressed    = (stable_next == pol);
        status.lp_ready   = (stable_next == pol) && !done_reg
                            && (elapsed > {{(TIME_W-DELAY_W){1'b0}}, long_press_time});
    end

    // long-press flag, kept apart so the fire path back from the merge stays acyclic
    always_comb
    begin
        done_next = done_reg;
        if (status.release_ev)
        begin
            done_next = 1'b0;
        end
        else if (lp_fire)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b1;
            stable_reg <= 1'b1;
            change_reg <= '0;
            done_reg   <= 1'b0;
        end
        else if (accept)
        begin
            prev_reg   <= prev_next;
            stable_reg <= stable_next;
            change_reg <= change_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbd_merge.sv @@
// ---------------------------------------------------------------------------
// bbd_merge
// combines lane findings into the result word and picks the long press
// ---------------------------------------------------------------------------
`default_nettype none

module bbd_merge #(
    parameter int NUM_BUTTONS = 8
) (
    input  bbd_pkg::lane_status_t          lanes [NUM_BUTTONS],
    input  wire logic                      lp_enable,
    input  wire logic [bbd_pkg::SEL_W-1:0] lp_button,
    output logic [NUM_BUTTONS-1:0]         lp_fire,
    output bbd_pkg::result_t               result
);
    import bbd_pkg::*;

    logic sel_ok;
    logic any_event;

    assign sel_ok = lp_enable && (32'(lp_button) < NUM_BUTTONS);

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            lp_fire[i] = sel_ok && (32'(lp_button) == i) && lanes[i].lp_ready;
        end
    end

    // every lane counts toward detection, also those past the result masks
    always_comb
    begin
        any_event = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            any_event = any_event || lanes[i].press || lanes[i].release_ev;
        end
    end

    always_comb
    begin
        result = '0;
        for (int i = 0; i < RAW_W; i++)
        begin
            if (i < NUM_BUTTONS)
            begin
                result.press_mask[i]     = lanes[i].press;
                result.release_mask[i]   = lanes[i].release_ev;
                result.stable_pressed[i] = lanes[i].pressed;
            end
        end
        result.long_press_event = |lp_fire;
        result.input_detected   = any_event || result.long_press_event;
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the button bank debouncer with long-press detect
// ---------------------------------------------------------------------------
// A directed table walks reset behavior, the debounce boundary, zero and
// full-scale delays, timestamp wrap, polarity change, long press together
// with a press and writes to unused register indexes. Random phases follow,
// each with its own register setting and one of four patterns of sender gaps
// and receiver stalls, driving bouncing button gestures on an advancing clock.
// Every result word is compared field by field with an in-bench model or a typed row.
`default_nettype none

module tb_top;
    import bbd_pkg::*;

    localparam int NBTN          = 8;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 152;
    localparam int DRAIN_CYCLES  = 4;
    localparam int LIMIT_CYCLES  = 400000;

    // register indexes the block does not decode
    localparam logic [IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic               is_cfg;
        logic [IDX_W-1:0]   idx;
        logic [CFG_W-1:0]   data;
        logic [TIME_W-1:0]  now;
        logic [RAW_W-1:0]   raw;
        logic               typed;
        result_t            res;
    } dir_row_t;

    localparam int PLAN_LEN = 31;

    // typed results: '{detected, stable_pressed, long_press, release, press}
    localparam dir_row_t PLAN [PLAN_LEN] = '{
        '{1'b0, '0, '0, 32'd0, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
        '{1'b0, '0, '0, 32'd100, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
        '{1'b0, '0, '0, 32'd200, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
        // exactly at the delay: not yet stable
        '{1'b0, '0, '0, 32'd250, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
        '{1'b0, '0, '0, 32'd251, 8'h00, 1'b1, '{1'b1, 8'hFF, 1'b0, 8'h00, 8'hFF}},
        '{1'b0, '0, '0, 32'd300, 8'hFF, 1'b1, '{1'b0, 8'hFF, 1'b0, 8'h00, 8'h00}},
        '{1'b0, '0, '0, 32'd351, 8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0, 8'hFF, 8'h00}},
        '{1'b1, CFG_DEBOUNCE_DELAY, 16'h0000, '0, '0, 1'b0, '0},
        '{1'b1, CFG_LONG_PRESS_TIME, 16'h0000, '0, '0, 1'b0, '0},
        '{1'b1, CFG_LONG_PRESS_BTN, 16'h0003, '0, '0, 1'b0, '0},
        '{1'b1, CFG_LONG_PRESS_EN, 16'h0001, '0, '0, 1'b0, '0},
        '{1'b0, '0, '0, 32'd400, 8'hF7, 1'b1, '{1'b0, 8'h00, 1'b0, 8'h00, 8'h00}},
        // press and long press in the same poll
        '{1'b0, '0, '0, 32'd401, 8'hF7, 1'b1, '{1'b1, 8'h08, 1'b1, 8'h00, 8'h08}},
        '{1'b0, '0, '0, 32'd500, 8'hF7, 1'b1, '{1'b0, 8'h08, 1'b0, 8'h00, 8'h00}},
        // polarity flips under held state
        '{1'b1, CFG_PRESSED_POL, 16'hFFFF, '0, '0, 1'b0, '0},
        '{1'b0, '0, '0, 32'd501, 8'hF7, 1'b0, '0},
        '{1'b0, '0, '0, 32'd502, 8'h08, 1'b0, '0},
        '{1'b0, '0, '0, 32'd503, 8'h08, 1'b0, '0},
        '{1'b1, CFG_DEBOUNCE_DELAY, 16'hFFFF, '0, '0, 1'b0, '0},
        '{1'b1, CFG_LONG_PRESS_TIME, 16'hFFFF, '0, '0, 1'b0, '0},
        '{1'b1, CFG_LONG_PRESS_BTN, 16'hFFFF, '0, '0, 1'b0, '0},
        '{1'b1, CFG_SPARE_FIRST, 16'hFFFF, '0, '0, 1'b0, '0},
        '{1'b1, CFG_SPARE_LAST, 16'h5A5A, '0, '0, 1'b0, '0},
        // timestamp wraps between change and settle
        '{1'b0, '0, '0, 32'hFFFF_FFF0, 8'h55, 1'b0, '0},
        '{1'b0, '0, '0, 32'h0000_FFF0, 8'h55, 1'b0, '0},
        '{1'b0, '0, '0, 32'h0001_0000, 8'hAA, 1'b0, '0},
        '{1'b0, '0, '0, 32'h0002_0001, 8'hAA, 1'b0, '0},
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0},
        '{1'b1, CFG_LONG_PRESS_EN, 16'hFFFE, '0, '0, 1'b0, '0},
        '{1'b0, '0, '0, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 8'h00, 1'b0, '0}
    };

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // now_ms[31:0], raw_levels[39:32]
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // press_mask[7:0], release_mask[15:8], long_press_event[16],
    // stable_pressed[24:17], input_detected[25], zero[31:26]
    logic [OUT_DATA_W-1:0]  m_tdata;

    button_bank_debounce_long_press #(
        .NUM_BUTTONS (NBTN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // model registers and per-button state
    logic [DELAY_W-1:0] dly_ms   = DEBOUNCE_RESET;
    logic [DELAY_W-1:0] hold_ms  = LONG_PRESS_RESET;
    logic [RAW_W-1:0]   polarity = '0;
    logic               lp_en    = 1'b0;
    logic [SEL_W-1:0]   lp_btn   = '0;
    logic [NBTN-1:0]    last_raw = '1;
    logic [NBTN-1:0]    settled  = '1;
    logic [NBTN-1:0]    lp_fired = '0;
    logic [TIME_W-1:0]  edge_ms [NBTN] = '{default: '0};

    result_t            pending_results [$];
    int                 mismatches = 0;
    int                 cycle_count;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    logic               cur_typed = 1'b0;
    result_t            cur_typed_res = '0;

    // gesture generator state
    logic [TIME_W-1:0]  clock_ms = '0;
    logic [RAW_W-1:0]   target_lv = '1;
    logic [RAW_W-1:0]   bounce_mask = '0;
    int                 bounce_left = 0;

    function automatic void apply_cfg(input logic [IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE_DELAY:  dly_ms   = data[DELAY_W-1:0];
            CFG_LONG_PRESS_TIME: hold_ms  = data[DELAY_W-1:0];
            CFG_PRESSED_POL:     polarity = data[RAW_W-1:0];
            CFG_LONG_PRESS_EN:   lp_en    = data[0];
            CFG_LONG_PRESS_BTN:  lp_btn   = data[SEL_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic result_t debounce_poll(input logic [TIME_W-1:0] now,
                                              input logic [RAW_W-1:0] raw);
        result_t            r;
        logic [TIME_W-1:0]  elapsed;
        int                 w;
        r = '0;
        for (int i = 0; i < NBTN; i++)
        begin
            if (raw[i] != last_raw[i])
                edge_ms[i] = now;
            elapsed = now - edge_ms[i];
            if (elapsed > {16'd0, dly_ms} && raw[i] != settled[i])
            begin
                settled[i] = raw[i];
                if (raw[i] == polarity[i])
                    r.press_mask[i] = 1'b1;
                else
                begin
                    r.release_mask[i] = 1'b1;
                    lp_fired[i] = 1'b0;
                end
            end
            last_raw[i] = raw[i];
        end
        if (lp_en)
        begin
            w = int'(lp_btn);
            elapsed = now - edge_ms[w];
            if (settled[w] == polarity[w] && !lp_fired[w] && elapsed > {16'd0, hold_ms})
            begin
                lp_fired[w] = 1'b1;
                r.long_press_event = 1'b1;
            end
        end
        r.stable_pressed = ~(settled ^ polarity);
        r.input_detected = (|r.press_mask) | (|r.release_mask) | r.long_press_event;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // mostly short steps, some across the debounce or hold window, a few wild
    function automatic logic [TIME_W-1:0] time_step();
        int unsigned pick;
        int unsigned d;
        int unsigned h;
        d = 32'(dly_ms);
        h = 32'(hold_ms);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return $urandom_range(0, d / 8 + 1);
        else if (pick < 85)
            return $urandom_range(d / 2, d + d / 2 + 2);
        else if (pick < 96)
            return $urandom_range(h / 2, h + h / 2 + 2);
        return $urandom();
    endfunction

    // button gestures: a level flip followed by a short burst of bounce
    function automatic logic [RAW_W-1:0] next_raw();
        if ($urandom_range(0, 99) < 3)
            return RAW_W'($urandom_range(0, 255));
        if (bounce_left == 0 && $urandom_range(0, 99) < 10)
        begin
            bounce_mask = 8'd1 << $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0)
                bounce_mask |= RAW_W'($urandom_range(0, 255));
            target_lv ^= bounce_mask;
            bounce_left = $urandom_range(0, 5);
        end
        if (bounce_left > 0)
        begin
            bounce_left--;
            return target_lv ^ (bounce_mask & RAW_W'($urandom_range(0, 255)));
        end
        return target_lv;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (cfg_we)
                apply_cfg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
            begin
                want = debounce_poll(s_tdata[31:0], s_tdata[39:32]);
                if (cur_typed)
                    want = cur_typed_res;
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[RES_W-1:0];
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected word, expected none actual %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("press_mask", 32'(want.press_mask), 32'(got.press_mask));
                    check_field("release_mask", 32'(want.release_mask),
                                32'(got.release_mask));
                    check_field("long_press_event", 32'(want.long_press_event),
                                32'(got.long_press_event));
                    check_field("stable_pressed", 32'(want.stable_pressed),
                                32'(got.stable_pressed));
                    check_field("input_detected", 32'(want.input_detected),
                                32'(got.input_detected));
                end
            end
        end
    end

    task automatic send_poll(input logic [TIME_W-1:0] now, input logic [RAW_W-1:0] raw,
                             input logic typed, input result_t res);
        cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {raw, now};
        cur_typed = typed;
        cur_typed_res = res;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // let every word in flight come out before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        cfg_we <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < PLAN_LEN; k++)
        begin
            if (PLAN[k].is_cfg)
            begin
                settle();
                cfg_write(PLAN[k].idx, PLAN[k].data);
            end
            else
                send_poll(PLAN[k].now, PLAN[k].raw, PLAN[k].typed, PLAN[k].res);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            if (p == 0)
            begin
                cfg_write(CFG_DEBOUNCE_DELAY, DEBOUNCE_RESET);
                cfg_write(CFG_LONG_PRESS_TIME, LONG_PRESS_RESET);
                cfg_write(CFG_PRESSED_POL, 16'h0000);
                cfg_write(CFG_LONG_PRESS_EN, 16'h0001);
                cfg_write(CFG_LONG_PRESS_BTN, 16'h0000);
            end
            else if (p == 1)
            begin
                cfg_write(CFG_DEBOUNCE_DELAY, 16'h0000);
                cfg_write(CFG_LONG_PRESS_TIME, 16'h0000);
                cfg_write(CFG_PRESSED_POL, 16'h0000);
                cfg_write(CFG_LONG_PRESS_EN, 16'h0001);
                cfg_write(CFG_LONG_PRESS_BTN, 16'h0000);
            end
            else if (p == 2)
            begin
                cfg_write(CFG_DEBOUNCE_DELAY, 16'hFFFF);
                cfg_write(CFG_LONG_PRESS_TIME, 16'hFFFF);
                cfg_write(CFG_PRESSED_POL, 16'h00FF);
                cfg_write(CFG_LONG_PRESS_EN, 16'h0001);
                cfg_write(CFG_LONG_PRESS_BTN, 16'h0007);
            end
            else
            begin
                cfg_write(CFG_DEBOUNCE_DELAY, CFG_W'($urandom_range(0, 40)));
                cfg_write(CFG_LONG_PRESS_TIME, CFG_W'($urandom_range(0, 120)));
                cfg_write(CFG_PRESSED_POL, CFG_W'($urandom_range(0, 16'hFFFF)));
                cfg_write(CFG_LONG_PRESS_EN, CFG_W'($urandom_range(0, 3) != 0));
                cfg_write(CFG_LONG_PRESS_BTN, CFG_W'($urandom_range(0, 16'hFFFF)));
            end
            cfg_write(IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      CFG_W'($urandom_range(0, 16'hFFFF)));

            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct = 9;
                    recv_stall_pct = 9;
                end
            endcase

            // some phases start just short of the timestamp wrap
            if (p % 3 == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            else
                clock_ms += $urandom_range(0, 5000);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                clock_ms += time_step();
                send_poll(clock_ms, next_raw(), 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ button_bank_debounce_long_press.f @@
+incdir+rtl
rtl/bbd_pkg.sv
rtl/bbd_lane.sv
rtl/bbd_merge.sv
rtl/button_bank_debounce_long_press.sv
bench/tb_top.sv
